[rtl/geo_pkg.sv]
package geo_pkg;

	localparam int MAX_CHARS = 12;
	localparam int FRAC_BITS = 24;
	localparam int AXIS_BITS = 30;
	localparam int CODE_W    = 2 * AXIS_BITS;
	localparam int SYM_W     = 5;
	localparam int ASCII_W   = 7;
	localparam int CNT_W     = 4;
	localparam int LAT_W     = 32;
	localparam int LON_W     = 33;
	localparam int LAT_RW    = 32;
	localparam int LON_RW    = 33;

	localparam logic [CNT_W-1:0] CHAR_RESET = CNT_W'(9);
	localparam logic [CNT_W-1:0] CHAR_MAX   = CNT_W'(MAX_CHARS);

	localparam logic [LAT_RW-1:0] LAT_SPAN = LAT_RW'(180) << FRAC_BITS;
	localparam logic [LON_RW-1:0] LON_SPAN = LON_RW'(360) << FRAC_BITS;

	localparam logic signed [LAT_W:0] LAT_LIM = (LAT_W + 1)'(90) << FRAC_BITS;
	localparam logic signed [LON_W:0] LON_LIM = (LON_W + 1)'(180) << FRAC_BITS;

	localparam logic [ASCII_W-1:0] ALPHABET [32] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
		7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
		7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
	};

	typedef struct packed {
		logic              valid;
		logic              err;
		logic [LAT_RW-1:0] lat_r;
		logic [LON_RW-1:0] lon_r;
		logic [CODE_W-1:0] code;
	} cell_t;

endpackage

[rtl/geo_cell.sv]
module geo_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  geo_pkg::cell_t c_in,
	output geo_pkg::cell_t c_out
);

	logic [geo_pkg::LAT_RW:0]   lat2;
	logic [geo_pkg::LON_RW:0]   lon2;
	logic                       lat_ge;
	logic                       lon_ge;
	logic [geo_pkg::LAT_RW-1:0] lat_nx;
	logic [geo_pkg::LON_RW-1:0] lon_nx;

	logic                       valid_q;
	logic                       err_q;
	logic [geo_pkg::LAT_RW-1:0] lat_q;
	logic [geo_pkg::LON_RW-1:0] lon_q;
	logic [geo_pkg::CODE_W-1:0] code_q;

	// one bisection step per axis: double the remainder, subtract span if it fits
	always_comb begin
		lat2   = {c_in.lat_r, 1'b0};
		lon2   = {c_in.lon_r, 1'b0};
		lat_ge = lat2 >= {1'b0, geo_pkg::LAT_SPAN};
		lon_ge = lon2 >= {1'b0, geo_pkg::LON_SPAN};
		lat_nx = lat_ge ? geo_pkg::LAT_RW'(lat2 - {1'b0, geo_pkg::LAT_SPAN})
		                : geo_pkg::LAT_RW'(lat2);
		lon_nx = lon_ge ? geo_pkg::LON_RW'(lon2 - {1'b0, geo_pkg::LON_SPAN})
		                : geo_pkg::LON_RW'(lon2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= c_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_q  <= c_in.err;
			lat_q  <= lat_nx;
			lon_q  <= lon_nx;
			code_q <= {c_in.code[geo_pkg::CODE_W-3:0], lon_ge, lat_ge};
		end
	end

	assign c_out.valid = valid_q;
	assign c_out.err   = err_q;
	assign c_out.lat_r = lat_q;
	assign c_out.lon_r = lon_q;
	assign c_out.code  = code_q;

endmodule

[rtl/geo_serial.sv]
module geo_serial (
	input  logic                        clk,
	input  logic                        arst_n,
	input  geo_pkg::cell_t              tail,
	input  logic [geo_pkg::CNT_W-1:0]   n,
	output logic                        take,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [geo_pkg::SYM_W-1:0]   symbol,
	output logic [geo_pkg::ASCII_W-1:0] ascii_char,
	output logic                        last,
	output logic                        range_error
);

	logic                       busy_q;
	logic                       err_q;
	logic [geo_pkg::CNT_W-1:0]  left_q;
	logic [geo_pkg::CODE_W-1:0] code_q;
	logic [geo_pkg::SYM_W-1:0]  sym;
	logic                       out_free;
	logic                       emit;
	logic                       fin;

	assign sym      = code_q[geo_pkg::CODE_W-1 -: geo_pkg::SYM_W];
	assign out_free = !out_valid || !out_stall;
	assign emit     = busy_q && out_free;
	assign fin      = emit && (left_q == geo_pkg::CNT_W'(1));
	assign take     = tail.valid && (!busy_q || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (out_free) begin
				out_valid <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_q <= tail.code;
			err_q  <= tail.err;
			left_q <= tail.err ? geo_pkg::CNT_W'(1) : n;
		end else if (emit) begin
			code_q <= {code_q[geo_pkg::CODE_W-geo_pkg::SYM_W-1:0], geo_pkg::SYM_W'(0)};
			left_q <= left_q - geo_pkg::CNT_W'(1);
		end
		if (emit) begin
			symbol      <= err_q ? geo_pkg::SYM_W'(0) : sym;
			ascii_char  <= err_q ? geo_pkg::ASCII_W'(0) : geo_pkg::ALPHABET[sym];
			last        <= left_q == geo_pkg::CNT_W'(1);
			range_error <= err_q;
		end
	end

endmodule

[rtl/geohash_encoder.sv]
// Path from an accepted coordinate word to its first character word, in order:
// One entry register and thirty bisection cells, one bit pair per cell, then the serialiser.
// Throughput: one character word per cycle while out_stall is low; a pair gives char_count words,
// held to 1..12, or one word on error. The serialiser's output port sets the sustained rate.
// Reset: valid flags clear, char_count returns to 9.
module geohash_encoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [geo_pkg::CNT_W-1:0]          cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [geo_pkg::LAT_W-1:0]   lat_deg,
	input  logic signed [geo_pkg::LON_W-1:0]   lon_deg,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [geo_pkg::SYM_W-1:0]          symbol,
	output logic [geo_pkg::ASCII_W-1:0]        ascii_char,
	output logic                               last,
	output logic                               range_error
);

	logic [geo_pkg::CNT_W-1:0]     char_q;
	logic [geo_pkg::CNT_W-1:0]     n;
	logic                          adv;
	logic                          take;

	logic signed [geo_pkg::LAT_W:0] lat_x;
	logic signed [geo_pkg::LON_W:0] lon_x;
	logic [geo_pkg::LAT_W:0]        lat_sum;
	logic [geo_pkg::LON_W:0]        lon_sum;
	logic                           err;

	logic                       ent_valid_q;
	logic                       ent_err_q;
	logic [geo_pkg::LAT_RW-1:0] ent_lat_q;
	logic [geo_pkg::LON_RW-1:0] ent_lon_q;

	geo_pkg::cell_t chain [geo_pkg::AXIS_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= geo_pkg::CHAR_RESET;
		end else if (cfg_we) begin
			char_q <= cfg_wdata;
		end
	end

	assign n = (char_q == geo_pkg::CNT_W'(0)) ? geo_pkg::CNT_W'(1) :
	           (char_q > geo_pkg::CHAR_MAX)   ? geo_pkg::CHAR_MAX : char_q;

	always_comb begin
		lat_x   = {lat_deg[geo_pkg::LAT_W-1], lat_deg};
		lon_x   = {lon_deg[geo_pkg::LON_W-1], lon_deg};
		err     = (lat_x < -geo_pkg::LAT_LIM) || (lat_x > geo_pkg::LAT_LIM) ||
		          (lon_x < -geo_pkg::LON_LIM) || (lon_x > geo_pkg::LON_LIM);
		lat_sum = lat_x + geo_pkg::LAT_LIM;
		lon_sum = lon_x + geo_pkg::LON_LIM;
	end

	assign adv      = !chain[geo_pkg::AXIS_BITS].valid || take;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
		end else if (adv) begin
			ent_valid_q <= in_valid;
		end
	end

	// out-of-range words carry zero offsets; the error flag overrides the bits
	always_ff @(posedge clk) begin
		if (adv) begin
			ent_err_q <= err;
			ent_lat_q <= err ? '0 : lat_sum[geo_pkg::LAT_RW-1:0];
			ent_lon_q <= err ? '0 : lon_sum[geo_pkg::LON_RW-1:0];
		end
	end

	assign chain[0].valid = ent_valid_q;
	assign chain[0].err   = ent_err_q;
	assign chain[0].lat_r = ent_lat_q;
	assign chain[0].lon_r = ent_lon_q;
	assign chain[0].code  = '0;

	for (genvar i = 0; i < geo_pkg::AXIS_BITS; i++) begin : g_cell
		geo_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.c_in   (chain[i]),
			.c_out  (chain[i+1])
		);
	end

	geo_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.tail        (chain[geo_pkg::AXIS_BITS]),
		.n           (n),
		.take        (take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.symbol      (symbol),
		.ascii_char  (ascii_char),
		.last        (last),
		.range_error (range_error)
	);

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> last)
		else $error("error word without last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (symbol == '0 && ascii_char == '0))
		else $error("error word carries a character");

	a_stall_tail: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> chain[geo_pkg::AXIS_BITS].valid)
		else $error("input stalled with empty chain tail");

	a_char_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !range_error) |-> ascii_char == geo_pkg::ALPHABET[symbol])
		else $error("character code does not match symbol");

endmodule
